// ===== hw/rtl/slink_pkg.sv =====
// shared types and constants for the handshake serial link endpoint
package slink_pkg;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SEND_BIT  = 3'd1,
      PH_SEND_END1 = 3'd2,
      PH_SEND_END2 = 3'd3,
      PH_RECV_BIT  = 3'd4,
      PH_RECV_END  = 3'd5
   } phase_type;

   typedef struct packed {
      logic       master_clock_line;
      logic       slave_clock_line;
      logic       data_line;
      logic       send_request;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       master_clock_drive;
      logic       slave_clock_drive;
      logic       data_drive;
      logic       byte_valid;
      logic [7:0] received_byte;
      logic       send_done;
      logic       link_busy;
   } rsp_type;

endpackage

// ===== hw/rtl/slink_if.sv =====
// valid/ready channel interfaces for line samples in and drive results out
interface slink_req_if;
   logic       valid;
   logic       ready;
   logic       master_clock_line;
   logic       slave_clock_line;
   logic       data_line;
   logic       send_request;
   logic [7:0] send_byte;

   modport source (output valid, output master_clock_line, output slave_clock_line,
                   output data_line, output send_request, output send_byte,
                   input ready);
   modport sink   (input valid, input master_clock_line, input slave_clock_line,
                   input data_line, input send_request, input send_byte,
                   output ready);
endinterface

interface slink_rsp_if;
   logic       valid;
   logic       ready;
   logic       master_clock_drive;
   logic       slave_clock_drive;
   logic       data_drive;
   logic       byte_valid;
   logic [7:0] received_byte;
   logic       send_done;
   logic       link_busy;

   modport source (output valid, output master_clock_drive, output slave_clock_drive,
                   output data_drive, output byte_valid, output received_byte,
                   output send_done, output link_busy, input ready);
   modport sink   (input valid, input master_clock_drive, input slave_clock_drive,
                   input data_drive, input byte_valid, input received_byte,
                   input send_done, input link_busy, output ready);
endinterface

// ===== hw/rtl/slink_fsm.sv =====
// link phase state machine: advances one tick per accepted item
module slink_fsm
   import slink_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   phase_type  phase_ff, phase_in;
   logic [7:0] shift_ff, shift_in;
   logic [3:0] bit_ff, bit_in;
   logic       mclk_ff, mclk_in;
   logic       sclk_ff, sclk_in;
   logic       data_ff, data_in;
   logic       odd;
   logic       rx_valid;
   logic       tx_done;
   logic [7:0] rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         bit_ff   <= '0;
         mclk_ff  <= 1'b1;
         sclk_ff  <= 1'b1;
         data_ff  <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         bit_ff   <= bit_in;
         mclk_ff  <= mclk_in;
         sclk_ff  <= sclk_in;
         data_ff  <= data_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      bit_in   = bit_ff;
      mclk_in  = mclk_ff;
      sclk_in  = sclk_ff;
      data_in  = data_ff;
      rx_valid = 1'b0;
      tx_done  = 1'b0;
      rx_byte  = '0;
      odd      = bit_ff[0];
      case (phase_ff)
         PH_IDLE: begin
            // a low sender clock wins over a local send request
            if (!req.master_clock_line) begin
               sclk_in  = 1'b0;
               bit_in   = '0;
               phase_in = PH_RECV_BIT;
            end else if (req.send_request) begin
               mclk_in  = 1'b0;
               shift_in = req.send_byte;
               bit_in   = '0;
               phase_in = PH_SEND_BIT;
            end
         end
         PH_SEND_BIT: begin
            if (req.slave_clock_line == odd) begin
               data_in  = shift_ff[0];
               mclk_in  = ~odd;
               shift_in = {1'b0, shift_ff[7:1]};
               bit_in   = bit_ff + 4'd1;
               if (bit_in >= BITS_PER_BYTE) phase_in = PH_SEND_END1;
            end
         end
         PH_SEND_END1: begin
            if (!req.slave_clock_line) begin
               mclk_in  = 1'b1;
               phase_in = PH_SEND_END2;
            end
         end
         PH_SEND_END2: begin
            if (req.slave_clock_line) begin
               data_in  = 1'b1;
               tx_done  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_RECV_BIT: begin
            if (req.master_clock_line == ~odd) begin
               shift_in = {req.data_line, shift_ff[7:1]};
               sclk_in  = ~odd;
               bit_in   = bit_ff + 4'd1;
               if (bit_in >= BITS_PER_BYTE) phase_in = PH_RECV_END;
            end
         end
         PH_RECV_END: begin
            if (req.master_clock_line) begin
               sclk_in  = 1'b1;
               rx_valid = 1'b1;
               rx_byte  = shift_ff;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // result reflects the line drives after this tick
   always_comb begin
      rsp.master_clock_drive = mclk_in;
      rsp.slave_clock_drive  = sclk_in;
      rsp.data_drive         = data_in;
      rsp.byte_valid         = rx_valid;
      rsp.received_byte      = rx_byte;
      rsp.send_done          = tx_done;
      rsp.link_busy          = (phase_in != PH_IDLE);
   end

endmodule

// ===== hw/rtl/handshake_serial_link_endpoint_core.sv =====
// an accepted item's result is in the output register in the next cycle
// throughput: 1 item per cycle while the output is not stalled, set by the phase update in slink_fsm
// a new item is taken while the previous result waits, unless that result is stalled
// reset (synchronous, active high): phase idle, all line drives released, no result held
// top level: channel handshake, output register and the link state machine
module handshake_serial_link_endpoint_core
   import slink_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   slink_req_if.sink         req_if,
   slink_rsp_if.source       rsp_if
);

   req_type req;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    accept;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign req.master_clock_line = req_if.master_clock_line;
   assign req.slave_clock_line  = req_if.slave_clock_line;
   assign req.data_line         = req_if.data_line;
   assign req.send_request      = req_if.send_request;
   assign req.send_byte         = req_if.send_byte;

   slink_fsm u_fsm (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req),
      .rsp   (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid              = rsp_valid_ff;
   assign rsp_if.master_clock_drive = rsp_ff.master_clock_drive;
   assign rsp_if.slave_clock_drive  = rsp_ff.slave_clock_drive;
   assign rsp_if.data_drive         = rsp_ff.data_drive;
   assign rsp_if.byte_valid         = rsp_ff.byte_valid;
   assign rsp_if.received_byte      = rsp_ff.received_byte;
   assign rsp_if.send_done          = rsp_ff.send_done;
   assign rsp_if.link_busy          = rsp_ff.link_busy;

`ifndef ASSERT_OFF
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_if.valid)
      else $error("accepted item produced no result");

   a_done_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.byte_valid && rsp_if.send_done))
      else $error("receive and send completed on the same tick");

   a_rx_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.byte_valid) |->
         (!rsp_if.link_busy && rsp_if.slave_clock_drive && rsp_if.data_drive))
      else $error("byte completed but link not back to idle");

   a_tx_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.send_done) |->
         (!rsp_if.link_busy && rsp_if.master_clock_drive && rsp_if.data_drive))
      else $error("send completed but lines not released");
`endif

endmodule

// ===== dv/slink_link_checker.sv =====
// scoreboard for the link endpoint: predicts the drives for every item and compares results
module slink_link_checker
   import slink_pkg::*;
(
   input  logic clock,
   input  logic reset,
   slink_req_if req_mon,
   slink_rsp_if rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output logic link_busy_pred
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type  phase;
   logic [7:0] shift_reg;
   logic [3:0] bit_count;
   logic       mclk_drv;
   logic       sclk_drv;
   logic       data_drv;
   rsp_type    pending_drives[$];

   // one tick of the endpoint; returns the line drives and flags after the tick
   function automatic rsp_type advance_link(req_type it);
      rsp_type r;
      logic    odd;
      odd = bit_count[0];
      r = '0;
      case (phase)
         PH_IDLE: begin
            // a low sender clock wins over a pending send request
            if (!it.master_clock_line) begin
               sclk_drv = 1'b0;
               bit_count = '0;
               phase = PH_RECV_BIT;
            end else if (it.send_request) begin
               mclk_drv = 1'b0;
               shift_reg = it.send_byte;
               bit_count = '0;
               phase = PH_SEND_BIT;
            end
         end
         PH_SEND_BIT: begin
            if (it.slave_clock_line == odd) begin
               data_drv = shift_reg[0];
               mclk_drv = ~odd;
               shift_reg = shift_reg >> 1;
               bit_count = bit_count + 4'd1;
               if (bit_count >= BITS_PER_BYTE) phase = PH_SEND_END1;
            end
         end
         PH_SEND_END1: begin
            if (!it.slave_clock_line) begin
               mclk_drv = 1'b1;
               phase = PH_SEND_END2;
            end
         end
         PH_SEND_END2: begin
            if (it.slave_clock_line) begin
               data_drv = 1'b1;
               r.send_done = 1'b1;
               phase = PH_IDLE;
            end
         end
         PH_RECV_BIT: begin
            if (it.master_clock_line == ~odd) begin
               shift_reg = {it.data_line, shift_reg[7:1]};
               sclk_drv = ~odd;
               bit_count = bit_count + 4'd1;
               if (bit_count >= BITS_PER_BYTE) phase = PH_RECV_END;
            end
         end
         PH_RECV_END: begin
            if (it.master_clock_line) begin
               sclk_drv = 1'b1;
               r.byte_valid = 1'b1;
               r.received_byte = shift_reg;
               phase = PH_IDLE;
            end
         end
         default: begin
            phase = PH_IDLE;
         end
      endcase
      r.master_clock_drive = mclk_drv;
      r.slave_clock_drive = sclk_drv;
      r.data_drive = data_drv;
      r.link_busy = (phase != PH_IDLE);
      return r;
   endfunction

   function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      req_type item;
      rsp_type want;
      int      errs;
      if (reset) begin
         phase = PH_IDLE;
         shift_reg = '0;
         bit_count = '0;
         mclk_drv = 1'b1;
         sclk_drv = 1'b1;
         data_drv = 1'b1;
         pending_drives.delete();
         fail_count <= 0;
         pending_count <= 0;
         link_busy_pred <= 1'b0;
      end else begin
         errs = 0;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_drives.size() == 0) begin
               $error("result arrived with no item outstanding");
               errs++;
            end else begin
               want = pending_drives.pop_front();
               errs += field_diff("master_clock_drive", want.master_clock_drive,
                                  rsp_mon.master_clock_drive);
               errs += field_diff("slave_clock_drive", want.slave_clock_drive,
                                  rsp_mon.slave_clock_drive);
               errs += field_diff("data_drive", want.data_drive, rsp_mon.data_drive);
               errs += field_diff("byte_valid", want.byte_valid, rsp_mon.byte_valid);
               errs += field_diff("received_byte", want.received_byte,
                                  rsp_mon.received_byte);
               errs += field_diff("send_done", want.send_done, rsp_mon.send_done);
               errs += field_diff("link_busy", want.link_busy, rsp_mon.link_busy);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            item.master_clock_line = req_mon.master_clock_line;
            item.slave_clock_line = req_mon.slave_clock_line;
            item.data_line = req_mon.data_line;
            item.send_request = req_mon.send_request;
            item.send_byte = req_mon.send_byte;
            pending_drives.push_back(advance_link(item));
         end
         fail_count <= fail_count + errs;
         pending_count <= pending_drives.size();
         link_busy_pred <= (phase != PH_IDLE);
      end
   end

endmodule

// ===== dv/tb_handshake_serial_link_endpoint_core.sv =====
// testbench top for the link endpoint: clock, reset, line-sample stimulus and verdict
module tb_handshake_serial_link_endpoint_core
   import slink_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   int      fail_count;
   int      pending_count;
   logic    link_busy_pred;
   logic    no_idle = 1'b0;
   logic    plan_fixed = 1'b0;
   logic    plan_fill = 1'b0;
   int      items_driven = 0;
   req_type line_plan[$];

   slink_req_if req_bus ();
   slink_rsp_if rsp_bus ();

   handshake_serial_link_endpoint_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   slink_link_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .link_busy_pred (link_busy_pred)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int idle_cycles();
      if (no_idle) return 0;
      return $urandom_range(0, 14);
   endfunction

   // don't-care fields are random, or a fixed level in the directed part
   function automatic logic fill_bit();
      if (plan_fixed) return plan_fill;
      return $urandom_range(0, 1) != 0;
   endfunction

   function automatic logic [7:0] fill_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      return plan_fixed ? {8{plan_fill}} : v;
   endfunction

   // ticks where the awaited line has not moved yet
   function automatic int hold_count();
      if (plan_fixed) return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic req_type line_item(logic m, logic s, logic d, logic rq, logic [7:0] b);
      req_type it;
      it.master_clock_line = m;
      it.slave_clock_line = s;
      it.data_line = d;
      it.send_request = rq;
      it.send_byte = b;
      return it;
   endfunction

   // peer sends a byte to us: sender clock low, then one toggle per bit, then released
   task automatic plan_receive(logic [7:0] b);
      logic want;
      line_plan.push_back(line_item(1'b0, fill_bit(), fill_bit(), fill_bit(), fill_byte()));
      for (int i = 0; i < 8; i++) begin
         want = ~i[0];
         repeat (hold_count())
            line_plan.push_back(line_item(~want, fill_bit(), fill_bit(), fill_bit(),
                                          fill_byte()));
         line_plan.push_back(line_item(want, fill_bit(), b[i], fill_bit(), fill_byte()));
      end
      repeat (hold_count())
         line_plan.push_back(line_item(1'b0, fill_bit(), fill_bit(), fill_bit(), fill_byte()));
      line_plan.push_back(line_item(1'b1, fill_bit(), fill_bit(), fill_bit(), fill_byte()));
   endtask

   // we send a byte: peer receiver clock follows each toggle, then low and high to finish
   task automatic plan_send(logic [7:0] b);
      logic want;
      line_plan.push_back(line_item(1'b1, fill_bit(), fill_bit(), 1'b1, b));
      for (int i = 0; i < 10; i++) begin
         // eight bit toggles, then low for end of byte, then high as the final acknowledge
         want = (i < 8) ? i[0] : (i == 9);
         repeat (hold_count())
            line_plan.push_back(line_item(fill_bit(), ~want, fill_bit(), fill_bit(),
                                          fill_byte()));
         line_plan.push_back(line_item(fill_bit(), want, fill_bit(), fill_bit(), fill_byte()));
      end
   endtask

   task automatic drive_item(req_type it);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.master_clock_line <= it.master_clock_line;
      req_bus.slave_clock_line <= it.slave_clock_line;
      req_bus.data_line <= it.data_line;
      req_bus.send_request <= it.send_request;
      req_bus.send_byte <= it.send_byte;
      do @(posedge clock); while (!req_bus.ready);
      items_driven++;
   endtask

   task automatic drive_plan(int count);
      for (int i = 0; i < count && i < line_plan.size(); i++) drive_item(line_plan[i]);
      line_plan.delete();
   endtask

   // toggle both clock lines together until the endpoint settles back to idle
   task automatic recover_idle();
      logic lvl;
      lvl = 1'b1;
      do begin
         drive_item(line_item(lvl, lvl, fill_bit(), 1'b0, fill_byte()));
         req_bus.valid <= 1'b0;
         @(posedge clock);
         lvl = ~lvl;
      end while (link_busy_pred);
   endtask

   initial begin : responder
      int gap;
      forever begin
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin : stimulus
      int         kind;
      int         cut;
      logic [7:0] b;
      req_bus.valid <= 1'b0;
      req_bus.master_clock_line <= 1'b1;
      req_bus.slave_clock_line <= 1'b1;
      req_bus.data_line <= 1'b1;
      req_bus.send_request <= 1'b0;
      req_bus.send_byte <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // receive of all ones with a send request on every tick, then a send of all zeros
      plan_fixed = 1'b1;
      plan_fill = 1'b1;
      plan_receive(8'hFF);
      plan_fill = 1'b0;
      plan_send(8'h00);
      line_plan.push_back(line_item(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
      drive_plan(line_plan.size());
      plan_fixed = 1'b0;

      while (items_driven < 440) begin
         no_idle <= ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 99);
         case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         if (kind < 40) begin
            plan_receive(b);
            drive_plan(line_plan.size());
         end else if (kind < 80) begin
            plan_send(b);
            drive_plan(line_plan.size());
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 4))
               line_plan.push_back(line_item(1'b1, fill_bit(), fill_bit(), 1'b0, fill_byte()));
            drive_plan(line_plan.size());
         end else if (kind < 94) begin
            // transfer cut off part way
            if (kind % 2 == 0) plan_receive(b);
            else plan_send(b);
            cut = $urandom_range(1, line_plan.size() - 1);
            drive_plan(cut);
            recover_idle();
         end else begin
            repeat ($urandom_range(1, 8))
               line_plan.push_back(line_item(fill_bit(), fill_bit(), fill_bit(), fill_bit(),
                                             fill_byte()));
            drive_plan(line_plan.size());
            recover_idle();
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_handshake_serial_link_endpoint_core passed");
      end else begin
         $display("tb_handshake_serial_link_endpoint_core failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("tb_handshake_serial_link_endpoint_core failed");
      $finish;
   end

endmodule

// ===== handshake_serial_link_endpoint_core.f =====
hw/rtl/slink_pkg.sv
hw/rtl/slink_if.sv
hw/rtl/slink_fsm.sv
hw/rtl/handshake_serial_link_endpoint_core.sv
dv/slink_link_checker.sv
dv/tb_handshake_serial_link_endpoint_core.sv
